/* src/itdt_pkg.sv */
package itdt_pkg;

    localparam int DEFAULT_VALUE_WIDTH = 64;
    localparam int CHAR_W              = 7;
    localparam int DIGIT_W             = 4;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'd48;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'd45;

endpackage

/* src/itdt_front.sv */
module itdt_front
    import itdt_pkg::*;
#(
    parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
)
(
    input  logic [VALUE_WIDTH-1:0] value,
    input  logic                   signed_mode,
    output logic                   neg,
    output logic [VALUE_WIDTH-1:0] mag
);

    // negative only when signed and the sign bit is set; most negative value wraps to itself
    always_comb
    begin
        neg = signed_mode & value[VALUE_WIDTH-1];
        mag = neg ? (~value + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : value;
    end

endmodule

/* src/itdt_queue.sv */
module itdt_queue
    import itdt_pkg::*;
#(
    parameter int DATA_W = DEFAULT_VALUE_WIDTH + 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    output logic [DATA_W-1:0] rd_data,
    output logic              q_full,
    output logic              q_empty
);

    logic [DATA_W-1:0] mem_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;

    logic do_wr;
    logic do_rd;

    assign do_wr   = wr_en & ~q_full;
    assign do_rd   = rd_en & ~q_empty;
    assign q_full  = count_reg[1];
    assign q_empty = (count_reg == 2'd0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({do_wr, do_rd})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

/* src/itdt_back.sv */
module itdt_back
    import itdt_pkg::*;
#(
    parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_empty,
    input  logic                   q_neg,
    input  logic [VALUE_WIDTH-1:0] q_mag,
    output logic                   q_pop,
    output logic [CHAR_W-1:0]      character,
    output logic                   last,
    output logic                   empty,
    input  logic                   pop
);

    // decimal digits needed for VALUE_WIDTH bits (log10(2) ~ 0.30103)
    localparam int NDIG  = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int BCD_W = NDIG * DIGIT_W;
    localparam int BCW   = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
    localparam int DCW   = $clog2(NDIG + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_SKIP,
        ST_EMIT
    } state_t;

    state_t                 state_reg,    state_next;
    logic [VALUE_WIDTH-1:0] bin_reg,      bin_next;
    logic [BCD_W-1:0]       bcd_reg,      bcd_next;
    logic                   neg_reg,      neg_next;
    logic [BCW-1:0]         bit_cnt_reg,  bit_cnt_next;
    logic [DCW-1:0]         dig_cnt_reg,  dig_cnt_next;
    logic                   out_vld_reg,  out_vld_next;
    logic [CHAR_W-1:0]      char_reg,     char_next;
    logic                   last_reg,     last_next;

    logic [BCD_W-1:0]   bcd_adj;
    logic [DIGIT_W-1:0] top_digit;
    logic               slot_free;
    logic               load;

    assign top_digit = bcd_reg[BCD_W-1 -: DIGIT_W];
    assign slot_free = ~out_vld_reg | pop;
    assign character = char_reg;
    assign last      = last_reg;
    assign empty     = ~out_vld_reg;

    // double dabble: add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            if (bcd_reg[i*DIGIT_W +: DIGIT_W] > 4'd4)
            begin
                bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W] + 4'd3;
            end
            else
            begin
                bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W];
            end
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        bin_next     = bin_reg;
        bcd_next     = bcd_reg;
        neg_next     = neg_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        char_next    = char_reg;
        last_next    = last_reg;
        q_pop        = 1'b0;
        load         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop        = 1'b1;
                    bin_next     = q_mag;
                    neg_next     = q_neg;
                    bcd_next     = '0;
                    bit_cnt_next = BCW'(VALUE_WIDTH - 1);
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_WIDTH-1]};
                bin_next = bin_reg << 1;
                if (bit_cnt_reg == '0)
                begin
                    dig_cnt_next = DCW'(NDIG);
                    state_next   = neg_reg ? ST_SIGN : ST_SKIP;
                end
                else
                begin
                    bit_cnt_next = bit_cnt_reg - BCW'(1);
                end
            end
            ST_SIGN:
            begin
                if (slot_free)
                begin
                    load       = 1'b1;
                    char_next  = ASCII_MINUS;
                    last_next  = 1'b0;
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // drop leading zeros but always keep the units digit
                if ((top_digit == '0) && (dig_cnt_reg > DCW'(1)))
                begin
                    bcd_next     = bcd_reg << DIGIT_W;
                    dig_cnt_next = dig_cnt_reg - DCW'(1);
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    load         = 1'b1;
                    char_next    = ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, top_digit};
                    last_next    = (dig_cnt_reg == DCW'(1));
                    bcd_next     = bcd_reg << DIGIT_W;
                    dig_cnt_next = dig_cnt_reg - DCW'(1);
                    if (dig_cnt_reg == DCW'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load)
        begin
            out_vld_next = 1'b1;
        end
        else if (pop)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            bin_reg     <= '0;
            bcd_reg     <= '0;
            neg_reg     <= 1'b0;
            bit_cnt_reg <= '0;
            dig_cnt_reg <= '0;
            out_vld_reg <= 1'b0;
            char_reg    <= '0;
            last_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            bin_reg     <= bin_next;
            bcd_reg     <= bcd_next;
            neg_reg     <= neg_next;
            bit_cnt_reg <= bit_cnt_next;
            dig_cnt_reg <= dig_cnt_next;
            out_vld_reg <= out_vld_next;
            char_reg    <= char_next;
            last_reg    <= last_next;
        end
    end

endmodule

/* src/integer_to_decimal_text.sv */
// integer_to_decimal_text: converts a number to its decimal ascii text
//
// input queue side: drive value and signed_mode and raise push; a request is
// taken on a clock edge with push high and full low. signed_mode set treats
// value as two's complement and a negative number gets a leading '-'.
// output queue side: while empty is low, character/last show the oldest
// waiting character; it is taken on a clock edge with pop high. last marks
// the final character of each number. digits come most significant first,
// without leading zeros; zero gives a single '0'.
// conversion: a request is written into a two-entry job queue, the back end
// pulls it when idle, shifts its magnitude serially from binary to bcd,
// emits a minus sign if the number is negative, skips the leading zero
// digits one at a time and then emits the digits one character at a time.
// the back end works on one number at a time in its single shift-and-add-3
// converter, so a new number starts only after the last character of the
// one before is loaded; waiting requests sit in the job queue.
// a stalled receiver holds the output register; the converter waits and the
// job queue keeps taking requests until both entries are used.
// reset clears both queues and the converter; full and empty come up
// low and high.
module integer_to_decimal_text
    import itdt_pkg::*;
#(
    parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [VALUE_WIDTH-1:0] value,
    input  logic                   signed_mode,
    input  logic                   push,
    output logic                   full,
    output logic [CHAR_W-1:0]      character,
    output logic                   last,
    output logic                   empty,
    input  logic                   pop
);

    logic                   f_neg;
    logic [VALUE_WIDTH-1:0] f_mag;
    logic                   q_neg;
    logic [VALUE_WIDTH-1:0] q_mag;
    logic                   q_pop;
    logic                   q_empty;

    itdt_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .value       (value),
        .signed_mode (signed_mode),
        .neg         (f_neg),
        .mag         (f_mag)
    );

    itdt_queue #(
        .DATA_W (VALUE_WIDTH + 1)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data ({f_neg, f_mag}),
        .rd_en   (q_pop),
        .rd_data ({q_neg, q_mag}),
        .q_full  (full),
        .q_empty (q_empty)
    );

    itdt_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_neg     (q_neg),
        .q_mag     (q_mag),
        .q_pop     (q_pop),
        .character (character),
        .last      (last),
        .empty     (empty),
        .pop       (pop)
    );

`ifndef SYNTH
    // job queue cannot be full and empty at once
    assert property (@(posedge clk) disable iff (!rst_n) !(full && q_empty))
        else $error("job queue full and empty together");

    // every shown character is a digit or a minus sign
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((character == ASCII_MINUS) ||
                    ((character >= ASCII_ZERO) && (character <= ASCII_ZERO + 7'd9))))
        else $error("character out of range");

    // a minus sign is never the final character
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (character == ASCII_MINUS)) |-> !last)
        else $error("minus sign flagged as last");

    // the back end only pulls a job that exists
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
        else $error("job pulled from empty queue");
`endif

endmodule

/* verif/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import itdt_pkg::*;

    localparam int VW           = DEFAULT_VALUE_WIDTH;
    localparam int NUM_RANDOM   = 150;
    localparam int MAX_REPORTS  = 10;
    localparam int HOLD_CYCLES  = 500;
    localparam int DRAIN_CYCLES = 200;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
    } text_char_t;

    class text_scoreboard;
        text_char_t pending_chars[$];
        int         mismatches;

        // expands one accepted request into its expected characters
        function void note_number(logic [VW-1:0] number, logic sgn);
            logic [VW-1:0]      magnitude;
            logic [DIGIT_W-1:0] digits[$];
            logic               negative;
            text_char_t         c;
            negative  = sgn && number[VW-1];
            magnitude = negative ? (~number + 1'b1) : number;
            do
            begin
                digits.push_front(DIGIT_W'(magnitude % 10));
                magnitude = magnitude / 10;
            end
            while (magnitude != 0);
            if (negative)
            begin
                c.character = ASCII_MINUS;
                c.last      = 1'b0;
                pending_chars.push_back(c);
            end
            foreach (digits[i])
            begin
                c.character = ASCII_ZERO + CHAR_W'(digits[i]);
                c.last      = (i == digits.size() - 1);
                pending_chars.push_back(c);
            end
        endfunction

        function void check_char(logic [CHAR_W-1:0] character, logic last);
            text_char_t want;
            if (pending_chars.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected character %0d last %b with nothing pending",
                             character, last);
                return;
            end
            want = pending_chars.pop_front();
            if (character !== want.character || last !== want.last)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("character mismatch: expected %0d last %b, got %0d last %b",
                             want.character, want.last, character, last);
            end
        endfunction
    endclass

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic [VW-1:0]     value       = '0;
    logic              signed_mode = 1'b0;
    logic              push        = 1'b0;
    logic              pop         = 1'b0;
    logic              full;
    logic [CHAR_W-1:0] character;
    logic              last;
    logic              empty;

    text_scoreboard board = new();

    integer_to_decimal_text #(.VALUE_WIDTH(VW)) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .value       (value),
        .signed_mode (signed_mode),
        .push        (push),
        .full        (full),
        .character   (character),
        .last        (last),
        .empty       (empty),
        .pop         (pop)
    );

    always #5 clk = ~clk;

    // called at a falling edge; returns at a falling edge with push still high unless it chose to idle
    task send_number(input logic [VW-1:0] number, input logic sgn, input bit may_idle);
        int gap;
        value       = number;
        signed_mode = sgn;
        push        = 1'b1;
        do
            @(posedge clk);
        while (full);
        board.note_number(number, sgn);
        @(negedge clk);
        if (may_idle && $urandom_range(99) < 31)
        begin
            push = 1'b0;
            // mostly short gaps, now and then a long one that can span a whole conversion
            gap = ($urandom_range(9) == 0) ? $urandom_range(10, 120) : $urandom_range(1, 3);
            repeat (gap) @(negedge clk);
        end
    endtask

    initial
    begin
        logic [VW-1:0] number;
        logic [VW-1:0] tens;
        logic          sgn;
        int            kind;
        int            ndigits;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_number(64'd0, 1'b0, 1);
        send_number(64'd0, 1'b1, 1);
        send_number(64'd1, 1'b0, 1);
        send_number(64'd9, 1'b0, 1);
        send_number(64'd10, 1'b0, 1);
        send_number(64'd99, 1'b1, 1);
        send_number(64'd100, 1'b0, 1);
        send_number(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1);
        send_number(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1);
        send_number(64'h8000_0000_0000_0000, 1'b1, 1);
        send_number(64'h8000_0000_0000_0000, 1'b0, 1);
        send_number(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1);
        send_number(64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1);
        send_number(64'd10000000000000000000, 1'b0, 1);
        send_number(64'd9999999999999999999, 1'b0, 1);
        send_number(64'hFFFF_FFFF_FFFF_FFF6, 1'b1, 1);
        send_number(64'hFFFF_FFFF_FFFF_FFF7, 1'b1, 1);
        send_number(64'hFFFF_FFFF_FFFF_FFF6, 1'b0, 1);
        send_number(~64'd1000000000000000000 + 64'd1, 1'b1, 1);
        send_number(64'h5555_5555_5555_5555, 1'b1, 1);
        send_number(64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1);
        send_number(64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1);

        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            kind    = $urandom_range(3);
            ndigits = $urandom_range(1, 20);
            case (kind)
                0:
                begin
                    number = {$urandom, $urandom};
                    sgn    = 1'($urandom_range(1));
                end
                1, 2:
                begin
                    // a number with a chosen count of digits, negated for signed runs
                    number = VW'($urandom_range(1, 9));
                    for (int d = 1; d < ndigits; d++)
                        number = number * 10 + $urandom_range(9);
                    sgn = (kind == 2);
                    if (sgn)
                        number = ~number + 1'b1;
                end
                default:
                begin
                    // digit count rollover points
                    tens = VW'(1);
                    for (int d = 1; d < ndigits; d++)
                        tens = tens * 10;
                    number = tens + $urandom_range(2) - 1;
                    sgn    = 1'($urandom_range(1));
                    if (sgn && $urandom_range(1))
                        number = ~number + 1'b1;
                end
            endcase
            send_number(number, sgn, !(n >= 60 && n < 110));
        end
        push = 1'b0;

        while (board.pending_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.mismatches == 0 && board.pending_chars.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        int received;
        bit hold_done;
        received  = 0;
        hold_done = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_done && received >= 150)
            begin
                // back-pressure long enough for the job queue to fill
                pop = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1;
            end
            pop = (received >= 600 && received < 1000) || ($urandom_range(99) >= 31);
            @(posedge clk);
            if (pop && !empty)
            begin
                board.check_char(character, last);
                received++;
            end
        end
    end

    initial
    begin
        #5ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

/* integer_to_decimal_text.f */
src/itdt_pkg.sv
src/itdt_front.sv
src/itdt_queue.sv
src/itdt_back.sv
src/integer_to_decimal_text.sv
verif/tb.sv
